// ===== hdl/assert_macros.svh =====
// Assertion macros used by the checked module, bci_ctrl.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define BCI_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define BCI_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hdl/bci_pkg.sv =====
package bci_pkg;

    localparam int MAX_WIDTH_DEF  = 256;
    localparam int MAX_HEIGHT_DEF = 256;
    localparam int TAPS           = 4;

    localparam int SAMPLE_W  = 32;
    localparam int POS_W     = 25;
    localparam int CFG_W     = 9;
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_GRID_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GRID_HEIGHT = 2'd1;

    // Datapath widths.
    localparam int S_W    = 17;  // fraction 0 .. 1.0 in Q0.16 plus the integer bit
    localparam int S2_W   = 33;
    localparam int S3_W   = 49;
    localparam int KW_W   = 54;  // kernel polynomial before rounding
    localparam int C_W    = 38;  // neighbourhood value incl. extrapolated corners
    localparam int WT_W   = 20;  // Q4.16 weight, multiplier B operand
    localparam int MA_W   = 45;  // multiplier A operand
    localparam int P_W    = MA_W + WT_W;
    localparam int RS_W   = 61;  // row sum
    localparam int ACC_W  = 67;  // final accumulator
    localparam int FRAC_W = 16;

    typedef enum logic [2:0] {
        MOP_NONE,
        MOP_SQX,
        MOP_SQY,
        MOP_CUX,
        MOP_CUY,
        MOP_CW0,
        MOP_CW,
        MOP_HW
    } t_mop;

    typedef struct packed {
        logic       wr;
        logic       load;
        logic       rd_en;
        logic [3:0] rd_slot;
        t_mop       mop;
        logic [1:0] mm;
        logic [1:0] mn;
        logic       ext_col;
        logic       ext_row;
        logic       calc_w;
        logic       out_load;
    } t_cmd;

endpackage

// ===== hdl/bicubic_convolution_interpolator.sv =====
// Keys cubic convolution interpolator over a stored grid of signed Q16.16 samples.
// A request with req_type 0 writes one sample at (row, col) and gives no result; it is
// taken and the block is ready again at once. A request with req_type 1
// interpolates at the Q9.16 point (x_pos, y_pos) over a 4x4 neighbourhood and gives
// one saturated Q16.16 result with a flag that marks clipping. A query reads the sixteen
// neighbours from the sample memory one per cycle (the kernel powers are formed on the
// multiplier meanwhile), extrapolates the edge columns and then the edge rows, runs the
// twenty row and column products on the shared multiplier, and saturates the sum into
// the result register.
// A new request is accepted while a finished result still waits to be taken; a query
// only stalls at its end if the previous result is still held. The sample memory is not
// cleared by reset, so every entry a query touches must have been written first.
// The grid_width and grid_height registers are written on the configuration port,
// which is always ready, and should only be changed while the block is idle.
module bicubic_convolution_interpolator #(
    parameter int MAX_WIDTH  = bci_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = bci_pkg::MAX_HEIGHT_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // Request channel.
    input  logic                                i_valid,
    output logic                                o_ready,
    input  logic                                i_req_type,
    input  logic [7:0]                          i_col,
    input  logic [7:0]                          i_row,
    input  logic signed [bci_pkg::SAMPLE_W-1:0] i_sample,
    input  logic signed [bci_pkg::POS_W-1:0]    i_x_pos,
    input  logic signed [bci_pkg::POS_W-1:0]    i_y_pos,
    // Result channel.
    output logic                                o_valid,
    input  logic                                i_ready,
    output logic signed [bci_pkg::SAMPLE_W-1:0] o_value,
    output logic                                o_saturated,
    // Configuration write channel.
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [bci_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [bci_pkg::CFG_W-1:0]           i_cfg_data
);

    bci_pkg::t_cmd cmd;

    // Registers are plain flops, so a configuration write is always taken.
    assign o_cfg_ready = 1'b1;

    // The controller sequences fetch, extrapolation and the multiply schedule.
    bci_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .i_req_type (i_req_type),
        .i_ready    (i_ready),
        .o_ready    (o_ready),
        .o_valid    (o_valid),
        .o_cmd      (cmd)
    );

    // The datapath holds the sample memory, the neighbourhood, the weights, the
    // shared multiplier and the result register.
    bci_datapath #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_cfg_we    (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_col       (i_col),
        .i_row       (i_row),
        .i_sample    (i_sample),
        .i_x_pos     (i_x_pos),
        .i_y_pos     (i_y_pos),
        .o_value     (o_value),
        .o_saturated (o_saturated)
    );

endmodule

// ===== hdl/bci_ctrl.sv =====
`include "assert_macros.svh"

module bci_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    input  logic            i_req_type,
    input  logic            i_ready,
    output logic            o_ready,
    output logic            o_valid,
    output bci_pkg::t_cmd   o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_FETCH,
        S_EXTC,
        S_EXTR,
        S_MAC,
        S_DONE
    } t_state;

    typedef struct packed {
        bci_pkg::t_mop mop;
        logic [1:0]    m;
        logic [1:0]    n;
    } t_sched;

    t_state     r_state;
    logic [4:0] r_cnt;
    logic       r_out_valid;
    logic       accept;

    // Multiply schedule: row products and the weighted row sums are interleaved so
    // that each row sum is complete when its weighting multiply is issued.
    function automatic t_sched mac_sched(input logic [4:0] step);
        t_sched s;
        s = '{mop: bci_pkg::MOP_NONE, m: 2'd0, n: 2'd0};
        unique case (step)
            5'd0:  s = '{bci_pkg::MOP_CW0, 2'd0, 2'd0};
            5'd1:  s = '{bci_pkg::MOP_CW,  2'd0, 2'd1};
            5'd2:  s = '{bci_pkg::MOP_CW,  2'd0, 2'd2};
            5'd3:  s = '{bci_pkg::MOP_CW,  2'd0, 2'd3};
            5'd4:  s = '{bci_pkg::MOP_CW0, 2'd1, 2'd0};
            5'd5:  s = '{bci_pkg::MOP_HW,  2'd0, 2'd0};
            5'd6:  s = '{bci_pkg::MOP_CW,  2'd1, 2'd1};
            5'd7:  s = '{bci_pkg::MOP_CW,  2'd1, 2'd2};
            5'd8:  s = '{bci_pkg::MOP_CW,  2'd1, 2'd3};
            5'd9:  s = '{bci_pkg::MOP_CW0, 2'd2, 2'd0};
            5'd10: s = '{bci_pkg::MOP_HW,  2'd1, 2'd0};
            5'd11: s = '{bci_pkg::MOP_CW,  2'd2, 2'd1};
            5'd12: s = '{bci_pkg::MOP_CW,  2'd2, 2'd2};
            5'd13: s = '{bci_pkg::MOP_CW,  2'd2, 2'd3};
            5'd14: s = '{bci_pkg::MOP_CW0, 2'd3, 2'd0};
            5'd15: s = '{bci_pkg::MOP_HW,  2'd2, 2'd0};
            5'd16: s = '{bci_pkg::MOP_CW,  2'd3, 2'd1};
            5'd17: s = '{bci_pkg::MOP_CW,  2'd3, 2'd2};
            5'd18: s = '{bci_pkg::MOP_CW,  2'd3, 2'd3};
            5'd20: s = '{bci_pkg::MOP_HW,  2'd3, 2'd0};
            default: s = '{bci_pkg::MOP_NONE, 2'd0, 2'd0};
        endcase
        return s;
    endfunction

    assign o_ready = (r_state == S_IDLE);
    assign o_valid = r_out_valid;
    assign accept  = i_valid && o_ready;

    always_comb begin
        t_sched s;
        s     = mac_sched(r_cnt);
        o_cmd = '0;
        o_cmd.mop  = bci_pkg::MOP_NONE;
        o_cmd.wr   = accept && !i_req_type;
        o_cmd.load = accept && i_req_type;
        unique case (r_state)
            S_IDLE: begin
            end
            S_FETCH: begin
                o_cmd.rd_en   = (r_cnt < 5'd16);
                o_cmd.rd_slot = r_cnt[3:0];
                unique case (r_cnt)
                    5'd0:    o_cmd.mop = bci_pkg::MOP_SQX;
                    5'd1:    o_cmd.mop = bci_pkg::MOP_SQY;
                    5'd2:    o_cmd.mop = bci_pkg::MOP_CUX;
                    5'd3:    o_cmd.mop = bci_pkg::MOP_CUY;
                    default: o_cmd.mop = bci_pkg::MOP_NONE;
                endcase
            end
            S_EXTC: begin
                o_cmd.ext_col = 1'b1;
                o_cmd.calc_w  = 1'b1;
            end
            S_EXTR: begin
                o_cmd.ext_row = 1'b1;
            end
            S_MAC: begin
                o_cmd.mop = s.mop;
                o_cmd.mm  = s.m;
                o_cmd.mn  = s.n;
            end
            S_DONE: begin
                o_cmd.out_load = !r_out_valid || i_ready;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (o_cmd.load) begin
                        r_state <= S_FETCH;
                        r_cnt   <= '0;
                    end
                end
                S_FETCH: begin
                    if (r_cnt == 5'd16) begin
                        r_state <= S_EXTC;
                    end else begin
                        r_cnt <= r_cnt + 5'd1;
                    end
                end
                S_EXTC: begin
                    r_state <= S_EXTR;
                end
                S_EXTR: begin
                    r_state <= S_MAC;
                    r_cnt   <= '0;
                end
                S_MAC: begin
                    if (r_cnt == 5'd21) begin
                        r_state <= S_DONE;
                    end else begin
                        r_cnt <= r_cnt + 5'd1;
                    end
                end
                S_DONE: begin
                    if (o_cmd.out_load) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    `BCI_ASSERT_NEXT(a_query_starts_fetch, i_clk, i_rst_n, (accept && i_req_type), (r_state == S_FETCH && r_cnt == 5'd0), "query did not start the fetch")
    `BCI_ASSERT_NEXT(a_mac_ends_done, i_clk, i_rst_n, (r_state == S_MAC && r_cnt == 5'd21), (r_state == S_DONE), "multiply schedule overran")
    `BCI_ASSERT_NEXT(a_done_free_out, i_clk, i_rst_n, (r_state == S_DONE && !r_out_valid), (r_out_valid && r_state == S_IDLE), "free output register not loaded")

endmodule

// ===== hdl/bci_datapath.sv =====
module bci_datapath #(
    parameter int MAX_WIDTH  = bci_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = bci_pkg::MAX_HEIGHT_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  bci_pkg::t_cmd                       i_cmd,
    input  logic                                i_cfg_we,
    input  logic [bci_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [bci_pkg::CFG_W-1:0]           i_cfg_data,
    input  logic [7:0]                          i_col,
    input  logic [7:0]                          i_row,
    input  logic signed [bci_pkg::SAMPLE_W-1:0] i_sample,
    input  logic signed [bci_pkg::POS_W-1:0]    i_x_pos,
    input  logic signed [bci_pkg::POS_W-1:0]    i_y_pos,
    output logic signed [bci_pkg::SAMPLE_W-1:0] o_value,
    output logic                                o_saturated
);

    localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int AW    = $clog2(DEPTH);
    localparam int CW    = $clog2(MAX_WIDTH);
    localparam int RW    = $clog2(MAX_HEIGHT);
    localparam int C_W   = bci_pkg::C_W;
    localparam int WT_W  = bci_pkg::WT_W;
    localparam int MA_W  = bci_pkg::MA_W;
    localparam int P_W   = bci_pkg::P_W;
    localparam int RS_W  = bci_pkg::RS_W;
    localparam int ACC_W = bci_pkg::ACC_W;
    localparam int KW_W  = bci_pkg::KW_W;
    localparam int V_W   = ACC_W - bci_pkg::FRAC_W;

    typedef struct packed {
        logic [15:0]            base;
        logic [bci_pkg::S_W-1:0] s;
        logic                   lo;
        logic                   hi;
    } t_loc;

    logic [bci_pkg::SAMPLE_W-1:0] mem [DEPTH];
    logic [bci_pkg::SAMPLE_W-1:0] r_q;
    logic                         r_rd_vld;
    logic [3:0]                   r_rd_slot;

    logic [bci_pkg::CFG_W-1:0] r_grid_width;
    logic [bci_pkg::CFG_W-1:0] r_grid_height;

    logic [CW-1:0]              r_i;
    logic [RW-1:0]              r_j;
    logic [bci_pkg::S_W-1:0]    r_sx, r_sy;
    logic [bci_pkg::S2_W-1:0]   r_sx2, r_sy2;
    logic [bci_pkg::S3_W-1:0]   r_sx3, r_sy3;
    logic                       r_left, r_right, r_top, r_bottom;

    logic signed [C_W-1:0]   r_c  [4][4];
    logic signed [WT_W-1:0]  r_wx [4];
    logic signed [WT_W-1:0]  r_wy [4];
    logic signed [P_W-1:0]   r_p;
    bci_pkg::t_mop           r_p_op;
    logic signed [RS_W-1:0]  r_rowsum;
    logic signed [ACC_W-1:0] r_acc;
    logic signed [bci_pkg::SAMPLE_W-1:0] r_value;
    logic                    r_sat;

    logic [15:0] w_eff, h_eff;
    t_loc        loc_x, loc_y;
    logic        wr_en;
    logic [AW-1:0] waddr, raddr;
    logic [15:0] rrow, rcol;
    logic signed [MA_W-1:0] op_a;
    logic signed [WT_W-1:0] op_b;
    logic signed [V_W-1:0]  v;
    logic                   ovf;

    localparam logic signed [RS_W-1:0]  RS_BIAS  = RS_W'(32768);
    localparam logic signed [ACC_W-1:0] ACC_BIAS = ACC_W'(32768);

    function automatic logic [15:0] clamp_sz(input logic [bci_pkg::CFG_W-1:0] v_in,
                                             input logic [15:0] mx);
        logic [15:0] r;
        if (16'(v_in) < 16'd3) begin
            r = 16'd3;
        end else if (16'(v_in) > mx) begin
            r = mx;
        end else begin
            r = 16'(v_in);
        end
        return r;
    endfunction

    function automatic t_loc locate(input logic signed [bci_pkg::POS_W-1:0] p,
                                    input logic [15:0] size);
        t_loc r;
        logic signed [31:0] lim;
        lim = $signed({size - 16'd1, 16'h0000});
        if (p <= 0) begin
            r.base = 16'd0;
            r.s    = '0;
        end else if (32'(p) >= lim) begin
            r.base = size - 16'd2;
            r.s    = 17'h10000;
        end else begin
            r.base = {8'd0, p[23:16]};
            r.s    = {1'b0, p[15:0]};
        end
        r.lo = (r.base == 16'd0);
        r.hi = (r.base != 16'd0) && (r.base == size - 16'd2);
        return r;
    endfunction

    // Keys kernel, a = -1/2, exact in s then rounded half up to Q4.16.
    function automatic logic signed [WT_W-1:0] kern(input logic [bci_pkg::S_W-1:0] s,
                                                    input logic [bci_pkg::S2_W-1:0] s2,
                                                    input logic [bci_pkg::S3_W-1:0] s3,
                                                    input logic [1:0] k);
        logic signed [KW_W-1:0] sv, q2, q3, t, rs;
        sv = $signed(KW_W'(s));
        q2 = $signed(KW_W'(s2));
        q3 = $signed(KW_W'(s3));
        unique case (k)
            2'd0:    t = -(sv <<< 32) + (q2 <<< 17) - q3;
            2'd1:    t = ($signed(KW_W'(1)) <<< 49) + (q3 <<< 1) + q3 - (q2 <<< 18)
                         - (q2 <<< 16);
            2'd2:    t = (sv <<< 32) + (q2 <<< 18) - (q3 <<< 1) - q3;
            default: t = q3 - (q2 <<< 16);
        endcase
        rs = (t + ($signed(KW_W'(1)) <<< 32)) >>> 33;
        return rs[WT_W-1:0];
    endfunction

    function automatic logic signed [C_W-1:0] extrap(input logic signed [C_W-1:0] a,
                                                     input logic signed [C_W-1:0] b,
                                                     input logic signed [C_W-1:0] c);
        logic signed [C_W-1:0] d;
        d = a - b;
        return (d <<< 1) + d + c;
    endfunction

    assign w_eff = clamp_sz(r_grid_width, 16'(MAX_WIDTH));
    assign h_eff = clamp_sz(r_grid_height, 16'(MAX_HEIGHT));
    assign loc_x = locate(i_x_pos, w_eff);
    assign loc_y = locate(i_y_pos, h_eff);

    assign wr_en = i_cmd.wr && (16'(i_col) < 16'(MAX_WIDTH)) && (16'(i_row) < 16'(MAX_HEIGHT));
    assign waddr = AW'(32'(i_row) * 32'(MAX_WIDTH) + 32'(i_col));

    // Slot (m, n) holds row j+m-1, column i+n-1; slots off the grid read junk that
    // the extrapolation later overwrites.
    assign rrow  = 16'(r_j) + 16'(i_cmd.rd_slot[3:2]) - 16'd1;
    assign rcol  = 16'(r_i) + 16'(i_cmd.rd_slot[1:0]) - 16'd1;
    assign raddr = AW'(32'(rrow) * 32'(MAX_WIDTH) + 32'(rcol));

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[waddr] <= i_sample;
        end
        if (i_cmd.rd_en) begin
            r_q <= mem[raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grid_width  <= 9'd256;
            r_grid_height <= 9'd256;
        end else if (i_cfg_we) begin
            if (i_cfg_index == bci_pkg::CFG_GRID_WIDTH) begin
                r_grid_width <= i_cfg_data;
            end else if (i_cfg_index == bci_pkg::CFG_GRID_HEIGHT) begin
                r_grid_height <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_vld <= 1'b0;
            r_p_op   <= bci_pkg::MOP_NONE;
        end else begin
            r_rd_vld <= i_cmd.rd_en;
            r_p_op   <= i_cmd.mop;
        end
    end

    always_comb begin
        op_a = '0;
        op_b = '0;
        unique case (i_cmd.mop)
            bci_pkg::MOP_SQX: begin
                op_a = $signed(MA_W'(r_sx));
                op_b = $signed(WT_W'(r_sx));
            end
            bci_pkg::MOP_SQY: begin
                op_a = $signed(MA_W'(r_sy));
                op_b = $signed(WT_W'(r_sy));
            end
            bci_pkg::MOP_CUX: begin
                op_a = $signed(MA_W'(r_sx2));
                op_b = $signed(WT_W'(r_sx));
            end
            bci_pkg::MOP_CUY: begin
                op_a = $signed(MA_W'(r_sy2));
                op_b = $signed(WT_W'(r_sy));
            end
            bci_pkg::MOP_CW0, bci_pkg::MOP_CW: begin
                op_a = MA_W'(r_c[i_cmd.mm][i_cmd.mn]);
                op_b = r_wx[i_cmd.mn];
            end
            bci_pkg::MOP_HW: begin
                op_a = r_rowsum[RS_W-1:bci_pkg::FRAC_W];
                op_b = r_wy[i_cmd.mm];
            end
            default: begin
                op_a = '0;
                op_b = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_rd_slot <= i_cmd.rd_slot;
        r_p       <= op_a * op_b;

        if (i_cmd.load) begin
            r_i      <= loc_x.base[CW-1:0];
            r_j      <= loc_y.base[RW-1:0];
            r_sx     <= loc_x.s;
            r_sy     <= loc_y.s;
            r_left   <= loc_x.lo;
            r_right  <= loc_x.hi;
            r_top    <= loc_y.lo;
            r_bottom <= loc_y.hi;
            r_acc    <= ACC_BIAS;
        end

        unique case (r_p_op)
            bci_pkg::MOP_SQX: r_sx2 <= r_p[bci_pkg::S2_W-1:0];
            bci_pkg::MOP_SQY: r_sy2 <= r_p[bci_pkg::S2_W-1:0];
            bci_pkg::MOP_CUX: r_sx3 <= r_p[bci_pkg::S3_W-1:0];
            bci_pkg::MOP_CUY: r_sy3 <= r_p[bci_pkg::S3_W-1:0];
            bci_pkg::MOP_CW0: r_rowsum <= RS_W'(r_p) + RS_BIAS;
            bci_pkg::MOP_CW:  r_rowsum <= r_rowsum + RS_W'(r_p);
            bci_pkg::MOP_HW:  r_acc <= r_acc + ACC_W'(r_p);
            default: begin
            end
        endcase

        if (i_cmd.calc_w) begin
            for (int k = 0; k < bci_pkg::TAPS; k++) begin
                r_wx[k] <= kern(r_sx, r_sx2, r_sx3, 2'(k));
                r_wy[k] <= kern(r_sy, r_sy2, r_sy3, 2'(k));
            end
        end

        if (r_rd_vld) begin
            r_c[r_rd_slot[3:2]][r_rd_slot[1:0]] <= C_W'($signed(r_q));
        end else if (i_cmd.ext_col) begin
            for (int m = 0; m < bci_pkg::TAPS; m++) begin
                if (r_left) begin
                    r_c[m][0] <= extrap(r_c[m][1], r_c[m][2], r_c[m][3]);
                end
                if (r_right) begin
                    r_c[m][3] <= extrap(r_c[m][2], r_c[m][1], r_c[m][0]);
                end
            end
        end else if (i_cmd.ext_row) begin
            for (int n = 0; n < bci_pkg::TAPS; n++) begin
                if (r_top) begin
                    r_c[0][n] <= extrap(r_c[1][n], r_c[2][n], r_c[3][n]);
                end
                if (r_bottom) begin
                    r_c[3][n] <= extrap(r_c[2][n], r_c[1][n], r_c[0][n]);
                end
            end
        end

        if (i_cmd.out_load) begin
            r_sat <= ovf;
            if (ovf) begin
                r_value <= v[V_W-1] ? {1'b1, {(bci_pkg::SAMPLE_W-1){1'b0}}}
                                    : {1'b0, {(bci_pkg::SAMPLE_W-1){1'b1}}};
            end else begin
                r_value <= v[bci_pkg::SAMPLE_W-1:0];
            end
        end
    end

    assign v   = r_acc[ACC_W-1:bci_pkg::FRAC_W];
    assign ovf = (v[V_W-1:bci_pkg::SAMPLE_W-1] != {(V_W-bci_pkg::SAMPLE_W+1){v[bci_pkg::SAMPLE_W-1]}});

    assign o_value     = r_value;
    assign o_saturated = r_sat;

endmodule

// ===== tb/tb_bicubic_convolution_interpolator.sv =====
`timescale 1ns / 100ps

// One expected interpolation result.
typedef struct {
    logic signed [31:0] value;
    logic               saturated;
} t_interp_result;

typedef longint t_taps[4];

// Keeps a shadow copy of the sample grid and the size registers, works out the
// interpolated value of every accepted query and compares the block's results
// against it in order.
class interp_scoreboard;
    logic [31:0]    grid_mirror[65536];
    bit             written[65536];
    logic [8:0]     width_reg;
    logic [8:0]     height_reg;
    t_interp_result pending[$];
    int             mismatches;

    function new();
        width_reg  = 9'd256;
        height_reg = 9'd256;
        mismatches = 0;
    endfunction

    function void set_register(logic [1:0] index, logic [8:0] data);
        if (index == bci_pkg::CFG_GRID_WIDTH) begin
            width_reg = data;
        end else if (index == bci_pkg::CFG_GRID_HEIGHT) begin
            height_reg = data;
        end
    endfunction

    function int used_size(logic [8:0] reg_value);
        if (reg_value < 3) begin
            return 3;
        end
        if (reg_value > 256) begin
            return 256;
        end
        return reg_value;
    endfunction

    // Clamps a Q9.16 coordinate to the grid and splits it into cell and fraction.
    function void locate(logic signed [24:0] pos, int size, output int base,
                         output longint frac);
        longint p;
        p = pos;
        if (p <= 0) begin
            base = 0;
            frac = 0;
        end else if (p >= longint'(size - 1) * 65536) begin
            base = size - 2;
            frac = 65536;
        end else begin
            base = int'(p >>> 16);
            frac = p & 64'hFFFF;
        end
    endfunction

    // Rounds half up and shifts right arithmetically.
    function longint round_down(longint v, int n);
        return (v + (64'sd1 <<< (n - 1))) >>> n;
    endfunction

    function t_taps kernel_weights(longint s);
        t_taps  w;
        longint s2;
        longint s3;
        s2 = s * s;
        s3 = s2 * s;
        w[0] = round_down(-s * (64'sd1 <<< 32) + 2 * s2 * 65536 - s3, 33);
        w[1] = round_down((64'sd1 <<< 49) + 3 * s3 - 5 * s2 * 65536, 33);
        w[2] = round_down(s * (64'sd1 <<< 32) + 4 * s2 * 65536 - 3 * s3, 33);
        w[3] = round_down(s3 - s2 * 65536, 33);
        return w;
    endfunction

    function void note_request(logic req_type, logic [7:0] col, logic [7:0] row,
                               logic [31:0] sample, logic signed [24:0] x_pos,
                               logic signed [24:0] y_pos);
        int             ci;
        int             rj;
        int             w;
        int             h;
        int             rlo;
        int             rhi;
        int             clo;
        int             chi;
        longint         sx;
        longint         sy;
        longint         c[4][4];
        longint         row_sum;
        longint         acc;
        longint         v;
        t_taps          wx;
        t_taps          wy;
        t_interp_result res;
        if (req_type == 1'b0) begin
            grid_mirror[{row, col}] = sample;
            written[{row, col}]     = 1'b1;
            return;
        end
        w = used_size(width_reg);
        h = used_size(height_reg);
        locate(x_pos, w, ci, sx);
        locate(y_pos, h, rj, sy);
        wx  = kernel_weights(sx);
        wy  = kernel_weights(sy);
        rlo = (rj == 0) ? 1 : 0;
        rhi = (rj != 0 && rj == h - 2) ? 2 : 3;
        clo = (ci == 0) ? 1 : 0;
        chi = (ci != 0 && ci == w - 2) ? 2 : 3;
        for (int m = rlo; m <= rhi; m++) begin
            for (int n = clo; n <= chi; n++) begin
                c[m][n] = longint'($signed(grid_mirror[(rj + m - 1) * 256 + ci + n - 1]));
            end
            // A missing column is extrapolated from the three present ones.
            if (clo == 1) begin
                c[m][0] = 3 * (c[m][1] - c[m][2]) + c[m][3];
            end
            if (chi == 2) begin
                c[m][3] = 3 * (c[m][2] - c[m][1]) + c[m][0];
            end
        end
        for (int n = 0; n < 4; n++) begin
            if (rlo == 1) begin
                c[0][n] = 3 * (c[1][n] - c[2][n]) + c[3][n];
            end
            if (rhi == 2) begin
                c[3][n] = 3 * (c[2][n] - c[1][n]) + c[0][n];
            end
        end
        acc = 0;
        for (int m = 0; m < 4; m++) begin
            row_sum = 0;
            for (int n = 0; n < 4; n++) begin
                row_sum += c[m][n] * wx[n];
            end
            acc += round_down(row_sum, 16) * wy[m];
        end
        v = round_down(acc, 16);
        res.saturated = 1'b0;
        if (v > 64'sd2147483647) begin
            v = 64'sd2147483647;
            res.saturated = 1'b1;
        end else if (v < -64'sd2147483648) begin
            v = -64'sd2147483648;
            res.saturated = 1'b1;
        end
        res.value = v[31:0];
        pending.push_back(res);
    endfunction

    function void check_result(logic signed [31:0] value, logic saturated);
        t_interp_result want;
        if (pending.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) begin
                $display("Result %0d with no query outstanding", value);
            end
            return;
        end
        want = pending.pop_front();
        if (value !== want.value || saturated !== want.saturated) begin
            mismatches++;
            if (mismatches <= 10) begin
                $display("Result mismatch: expected value %0d sat %0b, got value %0d sat %0b",
                         want.value, want.saturated, value, saturated);
            end
        end
    endfunction
endclass

module tb_bicubic_convolution_interpolator;

    // The configuration index has four values but only two select a register; this one selects none.
    localparam logic [bci_pkg::CFG_IDX_W-1:0] CFG_NO_REGISTER = 2'd3;
    localparam int                   TOTAL_ITEMS     = 1800;
    localparam int                   QUERY_LATENCY   = 60;

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   i_valid;
    logic                   o_ready;
    logic                   i_req_type;
    logic [7:0]             i_col;
    logic [7:0]             i_row;
    logic signed [31:0]     i_sample;
    logic signed [24:0]     i_x_pos;
    logic signed [24:0]     i_y_pos;
    logic                   o_valid;
    logic                   i_ready;
    logic signed [31:0]     o_value;
    logic                   o_saturated;
    logic                   i_cfg_valid;
    logic                   o_cfg_ready;
    logic [bci_pkg::CFG_IDX_W-1:0] i_cfg_index;
    logic [bci_pkg::CFG_W-1:0]     i_cfg_data;

    interp_scoreboard sb;
    int               requests_sent;
    int               sender_idle_pct;
    int               receiver_idle_pct;

    bicubic_convolution_interpolator u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_req_type  (i_req_type),
        .i_col       (i_col),
        .i_row       (i_row),
        .i_sample    (i_sample),
        .i_x_pos     (i_x_pos),
        .i_y_pos     (i_y_pos),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_value     (o_value),
        .o_saturated (o_saturated),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // The idling pattern follows the progress of the stimulus: first a slow receiver,
    // then a slow sender, and in the last third neither side holds back.
    always @(requests_sent) begin
        if (requests_sent < TOTAL_ITEMS / 3) begin
            sender_idle_pct   = 14;
            receiver_idle_pct = 67;
        end else if (requests_sent < 2 * TOTAL_ITEMS / 3) begin
            sender_idle_pct   = 67;
            receiver_idle_pct = 14;
        end else begin
            sender_idle_pct   = 0;
            receiver_idle_pct = 0;
        end
    end

    // Result side: sample at the rising edge, change ready at the falling edge.
    initial begin
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_valid && i_ready) begin
                sb.check_result(o_value, o_saturated);
            end
            @(negedge i_clk);
            i_ready = ($urandom_range(99) >= receiver_idle_pct);
        end
    end

    // Issues one request. It is entered and left at a falling edge, with valid still
    // high so that a following request goes out without a gap unless the sender idles.
    task automatic send_request(logic req_type, logic [7:0] col, logic [7:0] row,
                                logic [31:0] sample, logic signed [24:0] x_pos,
                                logic signed [24:0] y_pos);
        while ($urandom_range(99) < sender_idle_pct) begin
            i_valid = 1'b0;
            @(negedge i_clk);
        end
        i_valid    = 1'b1;
        i_req_type = req_type;
        i_col      = col;
        i_row      = row;
        i_sample   = sample;
        i_x_pos    = x_pos;
        i_y_pos    = y_pos;
        do begin
            @(posedge i_clk);
        end while (!o_ready);
        sb.note_request(req_type, col, row, sample, x_pos, y_pos);
        requests_sent++;
        @(negedge i_clk);
    endtask

    task automatic write_sample(logic [7:0] col, logic [7:0] row, logic [31:0] sample);
        send_request(1'b0, col, row, sample, 25'($urandom()), 25'($urandom()));
    endtask

    // Sample values: mostly moderate, some over the full range and some at the limits,
    // so that extrapolation drives a fair share of results into saturation.
    function automatic logic [31:0] pick_sample();
        int pick;
        pick = $urandom_range(99);
        if (pick < 50) begin
            return $urandom_range(2097152) - 1048576;
        end else if (pick < 80) begin
            return $urandom();
        end
        case ($urandom_range(3))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return 32'h0000_0000;
            default: return 32'hFFFF_FFFF;
        endcase
    endfunction

    function automatic logic signed [24:0] pick_coord(int size);
        int pick;
        pick = $urandom_range(99);
        if (pick < 70) begin
            return 25'($signed($urandom_range((size + 3) * 65536)) - 25'sd131072);
        end else if (pick < 80) begin
            return 25'($urandom_range(size) <<< 16);
        end
        return 25'($urandom());
    endfunction

    // A query may only touch written entries, so any missing neighbour is written
    // first with a fresh value.
    task automatic query_at(logic signed [24:0] x_pos, logic signed [24:0] y_pos);
        int     ci;
        int     rj;
        int     w;
        int     h;
        longint frac;
        w = sb.used_size(sb.width_reg);
        h = sb.used_size(sb.height_reg);
        sb.locate(x_pos, w, ci, frac);
        sb.locate(y_pos, h, rj, frac);
        for (int r = (rj > 0 ? rj - 1 : 0); r <= (rj + 2 < h ? rj + 2 : h - 1); r++) begin
            for (int c = (ci > 0 ? ci - 1 : 0); c <= (ci + 2 < w ? ci + 2 : w - 1); c++) begin
                if (!sb.written[r * 256 + c]) begin
                    write_sample(8'(c), 8'(r), pick_sample());
                end
            end
        end
        send_request(1'b1, 8'($urandom()), 8'($urandom()), $urandom(), x_pos, y_pos);
    endtask

    // Holds the sender back until every query has been answered and the block has had
    // time to finish any trailing write.
    task automatic wait_until_idle();
        i_valid = 1'b0;
        while (sb.pending.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (QUERY_LATENCY) @(negedge i_clk);
    endtask

    task automatic write_register(logic [bci_pkg::CFG_IDX_W-1:0] index,
                                  logic [bci_pkg::CFG_W-1:0] data);
        i_cfg_valid = 1'b1;
        i_cfg_index = index;
        i_cfg_data  = data;
        do begin
            @(posedge i_clk);
        end while (!o_cfg_ready);
        sb.set_register(index, data);
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    initial begin
        int            phase_end;
        logic [8:0]    widths[8];
        logic [8:0]    heights[8];
        logic [31:0]   edge_samples[9];
        logic signed [24:0] xs[10];
        logic signed [24:0] ys[10];
        sb                = new();
        requests_sent     = 0;
        sender_idle_pct   = 14;
        receiver_idle_pct = 67;
        i_clk       = 1'b0;
        i_rst_n     = 1'b0;
        i_valid     = 1'b0;
        i_ready     = 1'b0;
        i_req_type  = 1'b0;
        i_col       = '0;
        i_row       = '0;
        i_sample    = '0;
        i_x_pos     = '0;
        i_y_pos     = '0;
        i_cfg_valid = 1'b0;
        i_cfg_index = bci_pkg::CFG_GRID_WIDTH;
        i_cfg_data  = '0;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        // Directed part on the narrowest grid, where every cell sits on an edge.
        // The write to the unused index must leave both sizes alone.
        write_register(bci_pkg::CFG_GRID_WIDTH, 9'd3);
        write_register(bci_pkg::CFG_GRID_HEIGHT, 9'd3);
        write_register(CFG_NO_REGISTER, 9'd7);
        edge_samples = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000,
                         32'hFFFF_FFFF, 32'h0001_0000, 32'h7FFF_FFFF,
                         32'h8000_0000, 32'h1234_5678, 32'hFFFF_0000};
        for (int k = 0; k < 9; k++) begin
            write_sample(8'(k % 3), 8'(k / 3), edge_samples[k]);
        end
        xs = '{25'h100_0000, 25'h0FF_FFFF, 25'd0, 25'h1_0000, 25'h2_0000,
               25'h0_8000, 25'h1FF_FFFF, 25'h1_FFFF, 25'h0_0001, 25'h1_4000};
        ys = '{25'h100_0000, 25'h0FF_FFFF, 25'd0, 25'h1_0000, 25'h2_0000,
               25'h1_8000, 25'h0_0000, 25'h1_FFFF, 25'h0_FFFF, 25'h0_C000};
        for (int k = 0; k < 10; k++) begin
            query_at(xs[k], ys[k]);
        end
        // Let every result drain before anything else goes out.
        wait_until_idle();

        // Register settings, out-of-range values among them; the block clamps them.
        widths  = '{9'd0, 9'd511, 9'd7, 9'd256, 9'd2, 9'd16, 9'd1, 9'd12};
        heights = '{9'd511, 9'd3, 9'd5, 9'd256, 9'd9, 9'd3, 9'd257, 9'd12};
        for (int p = 0; p < 8; p++) begin
            wait_until_idle();
            write_register(bci_pkg::CFG_GRID_WIDTH, widths[p]);
            write_register(bci_pkg::CFG_GRID_HEIGHT, heights[p]);
            phase_end = requests_sent + TOTAL_ITEMS / 8;
            while (requests_sent < phase_end) begin
                if ($urandom_range(99) < 30) begin
                    // Writes anywhere in the store, also outside the grid in use.
                    if ($urandom_range(1)) begin
                        write_sample(8'($urandom()), 8'($urandom()), pick_sample());
                    end else begin
                        write_sample(8'($urandom_range(sb.used_size(sb.width_reg) - 1)),
                                     8'($urandom_range(sb.used_size(sb.height_reg) - 1)),
                                     pick_sample());
                    end
                end else begin
                    query_at(pick_coord(sb.used_size(sb.width_reg)),
                             pick_coord(sb.used_size(sb.height_reg)));
                end
            end
        end

        i_valid = 1'b0;
        fork
            begin
                while (sb.pending.size() != 0) begin
                    @(negedge i_clk);
                end
            end
            begin
                repeat (200000) @(negedge i_clk);
            end
        join_any
        disable fork;
        repeat (QUERY_LATENCY) @(negedge i_clk);
        if (sb.pending.size() == 0 && sb.mismatches == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

    // Watchdog against a hung handshake.
    initial begin
        #20ms;
        $display("== FAIL ==");
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+hdl
hdl/bci_pkg.sv
hdl/bci_ctrl.sv
hdl/bci_datapath.sv
hdl/bicubic_convolution_interpolator.sv
tb/tb_bicubic_convolution_interpolator.sv
